@@ sv/ir_prr_pkg.sv @@
// Shared types and constants for the infrared pulse record and replay block.
`default_nettype none

package ir_prr_pkg;

    localparam int SEGMENTS_DEF   = 48;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd3;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_REPLAY = 2'd1;
    localparam logic [1:0] MODE_PASS   = 2'd2;

    localparam logic [1:0] MODE_RST      = MODE_PASS;
    localparam logic [5:0] WIN_START_RST = 6'd0;
    localparam logic [5:0] WIN_END_RST   = 6'd47;
    localparam logic [7:0] REPEAT_RST    = 8'd1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic op;
        logic ir_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_level;
        logic       busy_res;
        logic       done_res;
        logic [5:0] segment_index;
    } t_out_item;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] window_start;
        logic [5:0] window_end;
        logic [7:0] repeat_count;
    } t_cfg;

    typedef enum logic [1:0] {
        CLS_TICK = 2'd0,
        CLS_REC  = 2'd1,
        CLS_PLAY = 2'd2,
        CLS_STOP = 2'd3
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic ir_level;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/ir_prr_ram.sv @@
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module ir_prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ sv/ir_prr_front.sv @@
// Front end: configuration registers, request classification and the command queue.
`default_nettype none

module ir_prr_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire ir_prr_pkg::t_in_item           i_in,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ir_prr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ir_prr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ir_prr_pkg::t_cfg                    o_cfg,
    output logic                                o_cmd_valid,
    output ir_prr_pkg::t_cmd                    o_cmd,
    input  wire logic                           i_cmd_take
);

    ir_prr_pkg::t_cfg r_cfg;
    ir_prr_pkg::t_cmd r_q [2];
    logic             r_rd_ptr;
    logic             r_wr_ptr;
    logic [1:0]       r_count;
    ir_prr_pkg::t_cmd n_cmd;
    logic             w_push_ok;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push_ok   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= ir_prr_pkg::MODE_RST;
            r_cfg.window_start <= ir_prr_pkg::WIN_START_RST;
            r_cfg.window_end   <= ir_prr_pkg::WIN_END_RST;
            r_cfg.repeat_count <= ir_prr_pkg::REPEAT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ir_prr_pkg::REG_MODE: begin
                    r_cfg.mode <= i_cfg_data[1:0];
                end
                ir_prr_pkg::REG_WIN_START: begin
                    r_cfg.window_start <= i_cfg_data[5:0];
                end
                ir_prr_pkg::REG_WIN_END: begin
                    r_cfg.window_end <= i_cfg_data[5:0];
                end
                ir_prr_pkg::REG_REPEAT: begin
                    r_cfg.repeat_count <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_cmd.ir_level = i_in.ir_level;
        case (i_in.op)
            ir_prr_pkg::OP_START: begin
                case (r_cfg.mode)
                    ir_prr_pkg::MODE_RECORD: n_cmd.cls = ir_prr_pkg::CLS_REC;
                    ir_prr_pkg::MODE_REPLAY: n_cmd.cls = ir_prr_pkg::CLS_PLAY;
                    default:                 n_cmd.cls = ir_prr_pkg::CLS_STOP;
                endcase
            end
            default: begin
                n_cmd.cls = ir_prr_pkg::CLS_TICK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr_ptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push_ok, i_cmd_take})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/ir_prr_back.sv @@
// Back end: record and replay engine, segment stores with prefetch, and the result queue.
`default_nettype none

module ir_prr_back #(
    parameter int SEGMENTS   = ir_prr_pkg::SEGMENTS_DEF,
    parameter int COUNT_BITS = ir_prr_pkg::COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ir_prr_pkg::t_cfg     i_cfg,
    input  wire logic                 i_cmd_valid,
    input  wire ir_prr_pkg::t_cmd     i_cmd,
    output logic                      o_cmd_take,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output ir_prr_pkg::t_out_item     o_out
);

    localparam int SEG_W = $clog2(SEGMENTS);
    localparam int CW    = ((SEG_W > 6) ? SEG_W : 6) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [SEG_W-1:0]      SEG_LAST = SEG_W'(SEGMENTS - 1);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_REC  = 3'b010,
        PH_PLAY = 3'b100
    } t_phase;

    function automatic logic [CW-1:0] f_sat(input logic [CW-1:0] x);
        return (x >= CW'(SEGMENTS)) ? CW'(SEGMENTS - 1) : x;
    endfunction

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [SEG_W-1:0]      r_cur, n_cur;
    logic [7:0]            r_rep, n_rep;
    logic                  r_ref, n_ref;
    logic                  r_cur_lvl, n_cur_lvl;

    logic [SEG_W-1:0]      r_pa_tag, r_pb_tag;
    logic                  r_pa_ok, r_pb_ok;

    logic                  lv_we, du_we;
    logic [SEG_W-1:0]      lv_waddr, du_waddr;
    logic                  lv_wdata;
    logic [SEG_W-1:0]      rd_addr_a, rd_addr_b;
    logic                  lv_rd_a, lv_rd_b;
    logic [COUNT_BITS-1:0] du_rd_a, du_rd_b;

    logic [CW-1:0]         ws_w, end_w, cur_w, nxt_w, ws_sat_w, ncur_w;
    logic                  ws_gt_end, pa_hit, pb_hit;
    logic                  need_a, need_b, stall, fire, room, pop_ok, idle;
    ir_prr_pkg::t_out_item res;

    ir_prr_pkg::t_out_item r_oq [2];
    logic                  r_oq_rd, r_oq_wr;
    logic [1:0]            r_oq_cnt;

    ir_prr_ram #(.WIDTH(1), .DEPTH(SEGMENTS)) u_level_ram (
        .i_clk     (i_clk),
        .i_we      (lv_we && fire),
        .i_waddr   (lv_waddr),
        .i_wdata   (lv_wdata),
        .i_raddr_a (rd_addr_a),
        .o_rdata_a (lv_rd_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_b (lv_rd_b)
    );

    ir_prr_ram #(.WIDTH(COUNT_BITS), .DEPTH(SEGMENTS)) u_duration_ram (
        .i_clk     (i_clk),
        .i_we      (du_we && fire),
        .i_waddr   (du_waddr),
        .i_wdata   (r_cnt),
        .i_raddr_a (rd_addr_a),
        .o_rdata_a (du_rd_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_b (du_rd_b)
    );

    assign ws_w      = CW'(i_cfg.window_start);
    assign end_w     = f_sat(CW'(i_cfg.window_end));
    assign ws_sat_w  = f_sat(ws_w);
    assign cur_w     = CW'(r_cur);
    assign ws_gt_end = ws_w > end_w;
    assign rd_addr_a = ws_sat_w[SEG_W-1:0];
    assign pa_hit    = r_pa_ok && (r_pa_tag == rd_addr_a);
    assign pb_hit    = r_pb_ok && (r_pb_tag == SEG_W'(r_cur + 1'b1));

    assign o_empty = (r_oq_cnt == 2'd0);
    assign o_out   = r_oq[r_oq_rd];
    assign pop_ok  = i_pop && !o_empty;
    assign room    = (r_oq_cnt != 2'd2) || pop_ok;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        n_rep     = r_rep;
        n_ref     = r_ref;
        n_cur_lvl = r_cur_lvl;
        lv_we     = 1'b0;
        lv_waddr  = r_cur;
        lv_wdata  = 1'b0;
        du_we     = 1'b0;
        du_waddr  = r_cur;
        need_a    = 1'b0;
        need_b    = 1'b0;
        idle      = 1'b0;
        res.drive_level = 1'b0;
        res.busy_res    = 1'b0;
        res.done_res    = 1'b0;

        case (i_cmd.cls)
            ir_prr_pkg::CLS_REC: begin
                n_phase  = PH_REC;
                n_cur    = '0;
                n_ref    = i_cmd.ir_level;
                n_cnt    = '0;
                lv_we    = 1'b1;
                lv_waddr = '0;
                lv_wdata = ~i_cmd.ir_level;
                res.drive_level = ~i_cmd.ir_level;
                res.busy_res    = 1'b1;
            end
            ir_prr_pkg::CLS_PLAY: begin
                if (i_cfg.repeat_count == 8'd0 || ws_gt_end) begin
                    n_phase      = PH_IDLE;
                    res.done_res = 1'b1;
                end else begin
                    need_a    = 1'b1;
                    n_phase   = PH_PLAY;
                    n_cur     = rd_addr_a;
                    n_rep     = 8'd0;
                    n_cnt     = du_rd_a;
                    n_cur_lvl = lv_rd_a;
                    res.drive_level = lv_rd_a;
                    res.busy_res    = 1'b1;
                end
            end
            ir_prr_pkg::CLS_STOP: begin
                n_phase = PH_IDLE;
                idle    = 1'b1;
            end
            default: begin
                case (r_phase)
                    PH_REC: begin
                        if (i_cmd.ir_level != r_ref || r_cnt == CNT_MAX) begin
                            du_we = 1'b1;
                            if (r_cur == SEG_LAST) begin
                                n_phase      = PH_IDLE;
                                res.done_res = 1'b1;
                            end else begin
                                n_cur    = r_cur + 1'b1;
                                n_ref    = i_cmd.ir_level;
                                n_cnt    = '0;
                                lv_we    = 1'b1;
                                lv_waddr = r_cur + 1'b1;
                                lv_wdata = ~i_cmd.ir_level;
                                res.drive_level = ~i_cmd.ir_level;
                                res.busy_res    = 1'b1;
                            end
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                            res.drive_level = ~r_ref;
                            res.busy_res    = 1'b1;
                        end
                    end
                    PH_PLAY: begin
                        if (r_cnt == '0) begin
                            if (cur_w < end_w) begin
                                need_b    = 1'b1;
                                n_cur     = r_cur + 1'b1;
                                n_cnt     = du_rd_b;
                                n_cur_lvl = lv_rd_b;
                                res.drive_level = lv_rd_b;
                                res.busy_res    = 1'b1;
                            end else if ({1'b0, r_rep} + 9'd1 >= {1'b0, i_cfg.repeat_count}
                                         || ws_gt_end) begin
                                n_phase      = PH_IDLE;
                                res.done_res = 1'b1;
                            end else begin
                                need_a    = 1'b1;
                                n_rep     = r_rep + 8'd1;
                                n_cur     = rd_addr_a;
                                n_cnt     = du_rd_a;
                                n_cur_lvl = lv_rd_a;
                                res.drive_level = lv_rd_a;
                                res.busy_res    = 1'b1;
                            end
                        end else begin
                            n_cnt = r_cnt - 1'b1;
                            res.drive_level = r_cur_lvl;
                            res.busy_res    = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        idle    = 1'b1;
                    end
                endcase
            end
        endcase

        if (idle) begin
            res.drive_level = (i_cfg.mode == ir_prr_pkg::MODE_PASS) ? ~i_cmd.ir_level : 1'b0;
        end
        ncur_w = CW'(n_cur);
        res.segment_index = ncur_w[5:0];
    end

    assign stall      = (need_a && !pa_hit) || (need_b && !pb_hit);
    assign fire       = i_cmd_valid && room && !stall;
    assign o_cmd_take = fire;
    assign nxt_w      = f_sat(CW'(fire ? n_cur : r_cur) + CW'(1));
    assign rd_addr_b  = nxt_w[SEG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_cur     <= '0;
            r_rep     <= 8'd0;
            r_ref     <= 1'b0;
            r_cur_lvl <= 1'b0;
        end else if (fire) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_cur     <= n_cur;
            r_rep     <= n_rep;
            r_ref     <= n_ref;
            r_cur_lvl <= n_cur_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_ok  <= 1'b0;
            r_pb_ok  <= 1'b0;
            r_pa_tag <= '0;
            r_pb_tag <= '0;
        end else begin
            r_pa_tag <= rd_addr_a;
            r_pb_tag <= rd_addr_b;
            r_pa_ok  <= !(fire && ((lv_we && lv_waddr == rd_addr_a)
                                   || (du_we && du_waddr == rd_addr_a)));
            r_pb_ok  <= !(fire && ((lv_we && lv_waddr == rd_addr_b)
                                   || (du_we && du_waddr == rd_addr_b)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_oq[r_oq_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_rd  <= 1'b0;
            r_oq_wr  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (fire) begin
                r_oq_wr <= ~r_oq_wr;
            end
            if (pop_ok) begin
                r_oq_rd <= ~r_oq_rd;
            end
            case ({fire, pop_ok})
                2'b10:   r_oq_cnt <= r_oq_cnt + 2'd1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 2'd1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/ir_pulse_record_replay.sv @@
// Top level of the infrared pulse record and replay block.
`default_nettype none

// Each request is one timer tick with the sampled receiver level, or a start command.
// The block takes one request per cycle while the result side keeps popping and no stall
// holds it, and returns exactly one result per request; each request passes through the
// command queue and then the result queue. Replay reads the segment stores through
// registered RAM ports that are prefetched one segment ahead; a stall occurs when
// that prefetch is stale, which happens only on the first replay step after
// window_start is written or after recording has just written the segment that a replay
// start needs. Configuration must be written only while no request is in flight.
module ir_pulse_record_replay #(
    parameter int SEGMENTS   = ir_prr_pkg::SEGMENTS_DEF,
    parameter int COUNT_BITS = ir_prr_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire ir_prr_pkg::t_in_item              i_in,
    output logic                                   empty,
    input  wire logic                              pop,
    output ir_prr_pkg::t_out_item                  o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ir_prr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ir_prr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ir_prr_pkg::t_cfg cfg;
    ir_prr_pkg::t_cmd cmd;
    logic             cmd_valid;
    logic             cmd_take;

    ir_prr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    ir_prr_back #(
        .SEGMENTS   (SEGMENTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
